[rtl/core/flsa_pkg.sv]
// Shared types and codes for the free-list slot allocator.
// Holds the action codes, controller state encoding and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package flsa_pkg;

  // Request action codes carried in a word on the input channel.
  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  // Controller states: ST_RELOAD is the cycle in which a popped head
  // is replaced by the link read from the link memory.
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RELOAD = 1'b1
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;  // an input word is taken at this edge
    logic reload;  // load the list head from the registered link
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pop_hit; // current input word pops the free list
  } dp_sts_t;

  localparam int unsigned CAP_W   = 11;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned LIVE_W  = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

endpackage

`default_nettype wire

[rtl/core/flsa_ctrl.sv]
// Controller for the free-list slot allocator: handshake and sequencing.
// Depends on flsa_pkg for the state type and command/status structs.
`default_nettype none

module flsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire flsa_pkg::dp_sts_t sts,
  output flsa_pkg::ctl_cmd_t     cmd
);
  import flsa_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    // A new word is taken when no head reload is pending and the output
    // register is empty or being drained at this edge.
    in_ready      = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    accept        = in_valid && in_ready;
    cmd.accept    = accept;
    cmd.reload    = (state_r == ST_RELOAD);
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && sts.pop_hit) begin
          state_nxt = ST_RELOAD;
        end
      end
      ST_RELOAD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_no_accept_in_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELOAD) |-> !in_ready)
    else $error("word accepted while the list head is being reloaded");

  a_pop_goes_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && sts.pop_hit) |=> (state_r == ST_RELOAD))
    else $error("free-list pop did not schedule a head reload");

  a_result_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept))
    else $error("result appeared without an accepted word");

endmodule

`default_nettype wire

[rtl/core/flsa_dp.sv]
// Datapath for the free-list slot allocator: list head, high-water mark,
// live count, capacity register, link memory and output register.
// Depends on flsa_pkg for action codes and command/status structs.
`default_nettype none

module flsa_dp #(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire flsa_pkg::ctl_cmd_t             cmd,
  output flsa_pkg::dp_sts_t                   sts,
  input  wire logic [1:0]                     in_action,
  input  wire logic [flsa_pkg::SLOT_W-1:0]    in_slot_to_free,
  input  wire logic                           cfg_wr_en,
  input  wire logic [flsa_pkg::CAP_W-1:0]     cfg_wr_data,
  output logic [flsa_pkg::SLOT_W-1:0]         out_slot_given,
  output logic                                out_status,
  output logic [flsa_pkg::LIVE_W-1:0]         out_live_slots
);
  import flsa_pkg::*;

  localparam int unsigned ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(POOL_DEPTH);
  localparam logic [CNT_W-1:0] LIVE_MAX  = CNT_W'(POOL_DEPTH);

  logic [CAP_W-1:0]  cap_r;
  logic              head_vld_r, head_vld_nxt;
  logic [ADDR_W-1:0] head_idx_r, head_idx_nxt;
  logic [CNT_W-1:0]  hw_r, hw_nxt;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic [ADDR_W:0]   rd_link_r;
  logic [ADDR_W:0]   link_mem [POOL_DEPTH];

  logic [SLOT_W-1:0] slot_nxt;
  logic              status_nxt;
  logic [CMP_W-1:0]  cap_ext, eff_cap;
  logic              head_ok, bump_ok, slot_in_pool, do_free;
  logic [ADDR_W-1:0] free_addr;
  action_t           act;

  always_comb begin
    act          = action_t'(in_action);
    cap_ext      = CMP_W'(cap_r);
    eff_cap      = (cap_ext > DEPTH_CMP) ? DEPTH_CMP : cap_ext;
    head_ok      = head_vld_r && (CMP_W'(head_idx_r) < eff_cap);
    bump_ok      = CMP_W'(hw_r) < eff_cap;
    slot_in_pool = CMP_W'(in_slot_to_free) < DEPTH_CMP;
    free_addr    = ADDR_W'(in_slot_to_free);
    do_free      = cmd.accept && (act == ACT_FREE) && slot_in_pool;
    sts.pop_hit  = (act == ACT_ALLOC) && head_ok;

    head_vld_nxt = head_vld_r;
    head_idx_nxt = head_idx_r;
    hw_nxt       = hw_r;
    live_nxt     = live_r;
    slot_nxt     = '0;
    status_nxt   = 1'b0;

    if (cmd.accept) begin
      case (act)
        ACT_ALLOC: begin
          if (head_ok) begin
            // Head is replaced by its link in the following cycle.
            slot_nxt = SLOT_W'(head_idx_r);
            if (live_r != LIVE_MAX) live_nxt = live_r + CNT_W'(1);
          end else if (bump_ok) begin
            slot_nxt = SLOT_W'(hw_r);
            hw_nxt   = hw_r + CNT_W'(1);
            if (live_r != LIVE_MAX) live_nxt = live_r + CNT_W'(1);
          end else begin
            status_nxt = 1'b1;
          end
        end
        ACT_FREE: begin
          if (slot_in_pool) begin
            head_vld_nxt = 1'b1;
            head_idx_nxt = free_addr;
            if (live_r != '0) live_nxt = live_r - CNT_W'(1);
          end
        end
        ACT_CLEAR: begin
          head_vld_nxt = 1'b0;
          head_idx_nxt = '0;
          hw_nxt       = '0;
          live_nxt     = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.reload) begin
      head_vld_nxt = rd_link_r[ADDR_W];
      head_idx_nxt = rd_link_r[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      head_vld_r <= 1'b0;
      head_idx_r <= '0;
      hw_r       <= '0;
      live_r     <= '0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      head_vld_r <= head_vld_nxt;
      head_idx_r <= head_idx_nxt;
      hw_r       <= hw_nxt;
      live_r     <= live_nxt;
    end
  end

  // Link memory: one write port for frees, one registered read of the head.
  always_ff @(posedge clk) begin
    if (do_free) link_mem[free_addr] <= {head_vld_r, head_idx_r};
    if (cmd.accept) rd_link_r <= link_mem[head_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_slot_given <= slot_nxt;
      out_status     <= status_nxt;
      out_live_slots <= LIVE_W'(live_nxt);
    end
  end

  a_hw_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(hw_r) <= DEPTH_CMP)
    else $error("high-water mark passed the pool depth");

  a_reload_takes_link: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reload |=> (head_vld_r == $past(rd_link_r[ADDR_W])) &&
                   (head_idx_r == $past(rd_link_r[ADDR_W-1:0])))
    else $error("list head not loaded from the popped link");

  a_full_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && (act == ACT_ALLOC) && !head_ok && !bump_ok)
      |=> $stable(hw_r) && $stable(live_r) && $stable(head_vld_r))
    else $error("refused allocate changed allocator state");

endmodule

`default_nettype wire

[rtl/core/free_list_slot_allocator_core.sv]
// Top level of the free-list slot allocator.
// Instantiates flsa_ctrl and flsa_dp; uses flsa_pkg for widths and types.
`default_nettype none

// Usage
//   The input channel (in_valid/in_ready) carries one word per request: an
//   action (allocate, free, clear, or a no-op code) and the slot index that a
//   free returns. The output channel (out_valid/out_ready) returns exactly one
//   word per request: the slot handed out, a full flag, and the live count
//   after the action. The capacity register is written through cfg_wr_en and
//   cfg_wr_data and should only be changed while the block is idle.
// Latency and throughput
//   A result word is registered and presented the cycle after its request is
//   accepted. Free, clear, no-op, bump allocates and refused allocates can stream
//   at one word per cycle while the receiver keeps taking results. An allocate
//   that pops the free list has the head's link read from the link
//   memory at acceptance and loaded into the head register in the next cycle,
//   during which no new word is accepted.
// Reset and stalls
//   rst_n is synchronous and active low. It empties the free list, zeroes the
//   high-water mark and live count, and sets the capacity to 1024. The link
//   memory is not cleared: a link is only read after a free has written it.
//   When the receiver holds out_ready low, the result word waits in the output
//   register and in_ready drops until it is taken or drains at the same edge.
module free_list_slot_allocator_core #(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_action,
  input  wire logic [flsa_pkg::SLOT_W-1:0]  in_slot_to_free,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [flsa_pkg::SLOT_W-1:0]       out_slot_given,
  output logic                              out_status,
  output logic [flsa_pkg::LIVE_W-1:0]       out_live_slots,
  input  wire logic                         cfg_wr_en,
  input  wire logic [flsa_pkg::CAP_W-1:0]   cfg_wr_data
);
  import flsa_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Controller owns the handshake and the head-reload sequencing.
  flsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath holds all allocator state and the result register.
  flsa_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_slot_to_free (in_slot_to_free),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_slot_given  (out_slot_given),
    .out_status      (out_status),
    .out_live_slots  (out_live_slots)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for free_list_slot_allocator_core.
// It depends on flsa_pkg for the action codes and field widths. A scoreboard class predicts
// every result word. Plain tasks drive the request and capacity ports, a loop the results.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import flsa_pkg::*;

  localparam int unsigned POOL        = 1024;
  localparam int unsigned STALL_LIMIT = 1000;  // cycles with no handshake at all
  localparam int unsigned LONG_HOLD   = 64;    // long receiver back-pressure stretch
  localparam int unsigned MAX_PRINTS  = 40;

  // One result word as the block returns it.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              full;
    logic [LIVE_W-1:0] live;
  } alloc_result_t;

  // The scoreboard keeps its own copy of the allocator: the list head, the
  // high-water mark, the live count and a link per slot. It also keeps the
  // slots that are currently handed out, so that the stimulus can return them.
  class alloc_scoreboard;
    logic [CAP_W-1:0]  capacity;
    logic              head_valid;
    logic [SLOT_W-1:0] head_slot;
    logic [CAP_W-1:0]  high_water;
    logic [LIVE_W-1:0] live_count;
    logic [SLOT_W:0]   link_mem [POOL];
    alloc_result_t     awaiting [$];
    logic [SLOT_W-1:0] held [$];
    int errors, results_seen, pops, bumps, refusals, frees, clears, saturations;

    function new();
      capacity   = CAP_RESET;
      head_valid = 1'b0;
      head_slot  = '0;
      high_water = '0;
      live_count = '0;
    endfunction

    // Works out the result word of an accepted request and queues it.
    function void note_request(action_t act, logic [SLOT_W-1:0] slot);
      alloc_result_t    r;
      logic [CAP_W-1:0] bound;
      r = '0;
      bound = (capacity > POOL) ? CAP_W'(POOL) : capacity;
      case (act)
        ACT_ALLOC: begin
          // A head slot at or above the bound is left on the list.
          if (head_valid && {1'b0, head_slot} < bound) begin
            r.slot = head_slot;
            {head_valid, head_slot} = link_mem[head_slot];
            pops++;
          end else if (high_water < bound) begin
            r.slot = high_water[SLOT_W-1:0];
            high_water++;
            bumps++;
          end else begin
            r.full = 1'b1;
            refusals++;
          end
          if (!r.full) begin
            held.push_back(r.slot);
            if (live_count < POOL) live_count++;
            else saturations++;
          end
        end
        ACT_FREE: begin
          // Frees are not checked: any slot is pushed, even one already free.
          link_mem[slot] = {head_valid, head_slot};
          head_valid = 1'b1;
          head_slot  = slot;
          if (live_count != 0) live_count--;
          for (int i = 0; i < held.size(); i++) begin
            if (held[i] == slot) begin
              held.delete(i);
              break;
            end
          end
          frees++;
        end
        ACT_CLEAR: begin
          head_valid = 1'b0;
          head_slot  = '0;
          high_water = '0;
          live_count = '0;
          held.delete();
          clears++;
        end
        default: ;
      endcase
      r.live = live_count;
      awaiting.push_back(r);
    endfunction

    task check_result(alloc_result_t got);
      alloc_result_t want;
      results_seen++;
      if (awaiting.size() == 0) begin
        report("word with nothing pending, live_slots", got.live, '0);
        return;
      end
      want = awaiting.pop_front();
      if (got.slot !== want.slot)
        report("slot_given", CAP_W'(got.slot), CAP_W'(want.slot));
      if (got.full !== want.full)
        report("status", CAP_W'(got.full), CAP_W'(want.full));
      if (got.live !== want.live) report("live_slots", got.live, want.live);
    endtask

    task report(string field, logic [CAP_W-1:0] got, logic [CAP_W-1:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("[%0t] mismatch on %s after %0d words: got %0d, expected %0d",
                 $time, field, results_seen, got, want);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_action;
  logic [SLOT_W-1:0] in_slot_to_free;
  logic              out_valid;
  logic              out_ready;
  logic [SLOT_W-1:0] out_slot_given;
  logic              out_status;
  logic [LIVE_W-1:0] out_live_slots;
  logic              cfg_wr_en;
  logic [CAP_W-1:0]  cfg_wr_data;

  alloc_scoreboard sb;
  bit no_gap_in, no_gap_out;   // when set, that side adds no random idle cycles
  int capacity_writes;
  int quiet_cycles;

  free_list_slot_allocator_core #(.POOL_DEPTH(POOL)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_slot_to_free (in_slot_to_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_slot_given  (out_slot_given),
    .out_status      (out_status),
    .out_live_slots  (out_live_slots),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Offers one request word. Every call starts and ends at a falling edge, so
  // the valid line is assigned once per time step: a word that follows with
  // no gap simply keeps valid high.
  task automatic send_word(input action_t act, input logic [SLOT_W-1:0] slot);
    int gap;
    gap = no_gap_in ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_slot_to_free <= slot;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(act, slot);
    @(negedge clk);
  endtask

  // The capacity is only rewritten once every pending result word has come
  // back. A pop keeps the input closed in the cycle after its acceptance,
  // which is over by the time its result is taken; the added wait before the
  // write is only margin. Each new setting also draws a new pace for both
  // sides, which gives stretches with no idling at all.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.awaiting.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.capacity = value;
    capacity_writes++;
    no_gap_in  = ($urandom_range(0, 3) == 0);
    no_gap_out = ($urandom_range(0, 3) == 0);
  endtask

  // Mostly well-formed traffic: allocates, and frees of slots that are really
  // held. The rest is stray frees of arbitrary slots, no-ops and the odd clear.
  task automatic random_phase(input int count);
    int                r;
    action_t           act;
    logic [SLOT_W-1:0] s;
    repeat (count) begin
      r = $urandom_range(0, 99);
      s = SLOT_W'($urandom);
      if (r < 50) begin
        act = ACT_ALLOC;
      end else if (r < 85) begin
        act = ACT_FREE;
        if (sb.held.size() != 0) s = sb.held[$urandom_range(0, sb.held.size() - 1)];
      end else if (r < 93) begin
        act = ACT_FREE;
      end else if (r < 98) begin
        act = ACT_NOP;
      end else begin
        act = ACT_CLEAR;
      end
      send_word(act, s);
    end
  endtask

  // Fills the whole pool from the high-water mark, shows one refusal, then
  // frees one slot twice. That turns the slot's link into a loop onto itself,
  // so allocates keep popping it and the live count runs into its ceiling.
  task automatic fill_pool();
    logic [SLOT_W-1:0] s;
    s = SLOT_W'($urandom);
    send_word(ACT_CLEAR, s);
    repeat (POOL + 1) begin
      s = SLOT_W'($urandom);
      send_word(ACT_ALLOC, s);
    end
    s = SLOT_W'($urandom);
    send_word(ACT_FREE, s);
    send_word(ACT_FREE, s);
    repeat (6) send_word(ACT_ALLOC, ~s);
  endtask

  // Result side. Every word is checked as it is taken. At a few points the
  // receiver holds off for a long stretch, so that the output register stays
  // full and the block has to hold off requests while the sender keeps offering.
  initial begin
    int            gap;
    alloc_result_t got;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (sb.results_seen % 500 == 200) gap = LONG_HOLD;
      else gap = no_gap_out ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.slot = out_slot_given;
      got.full = out_status;
      got.live = out_live_slots;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("No word moved for %0d cycles; %0d results still pending",
               quiet_cycles, sb.awaiting.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_NOP;
    in_slot_to_free = '0;
    out_ready       = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    quiet_cycles    = 0;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset capacity of 1024. Bump grants first, then a
    // no-op carrying a slot, a pop right after a free, and two pops back to
    // back, which exercises the reload cycle.
    send_word(ACT_ALLOC, 10'd0);
    send_word(ACT_ALLOC, 10'd1023);
    send_word(ACT_ALLOC, 10'd0);
    send_word(ACT_NOP, 10'd1023);
    send_word(ACT_FREE, 10'd1);
    send_word(ACT_ALLOC, 10'd0);
    send_word(ACT_ALLOC, 10'd0);
    send_word(ACT_FREE, 10'd2);
    send_word(ACT_FREE, 10'd0);
    send_word(ACT_ALLOC, 10'd0);
    send_word(ACT_ALLOC, 10'd0);
    // A slot that was never handed out, freed twice: both pushes are taken.
    send_word(ACT_FREE, 10'd5);
    send_word(ACT_FREE, 10'd5);
    send_word(ACT_ALLOC, 10'd0);
    send_word(ACT_ALLOC, 10'd0);
    // Clear, then a free at a live count of zero, which must stay at zero.
    send_word(ACT_CLEAR, 10'd1023);
    send_word(ACT_FREE, 10'd7);
    send_word(ACT_NOP, 10'd0);
    send_word(ACT_FREE, 10'd1023);

    // With a capacity of 4, the head slot 1023 lies beyond the bound: the
    // list is left alone, the mark serves four slots, and then the pool is full.
    write_capacity(11'd4);
    repeat (5) send_word(ACT_ALLOC, 10'd0);

    // Zero capacity refuses every allocate, even with slots on the list.
    write_capacity(11'd0);
    random_phase(25);

    write_capacity(11'd1);
    random_phase(25);
    repeat (3) begin
      write_capacity(CAP_W'($urandom_range(2, 40)));
      random_phase(25);
    end
    write_capacity(11'd1023);
    random_phase(25);
    // A capacity above the pool size is bounded by the pool size.
    write_capacity(11'd2047);
    random_phase(25);
    write_capacity(11'd1024);
    fill_pool();
    random_phase(25);

    in_valid <= 1'b0;
    while (sb.awaiting.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d result words: %0d list pops, %0d bump grants, %0d refusals,",
             sb.results_seen, sb.pops, sb.bumps, sb.refusals);
    $display("%0d frees, %0d clears, %0d capped live counts over %0d capacity settings.",
             sb.frees, sb.clears, sb.saturations, capacity_writes + 1);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
